### sv/swtb_pkg.sv
// shared constants and types of the stopwatch timer bank
package swtb_pkg;

    localparam int NUM_TIMERS_DEF = 8;

    localparam int OP_W    = 2;
    localparam int INDEX_W = 8;
    localparam int CYCLE_W = 32;
    localparam int CLOCK_W = 16;

    localparam logic [CLOCK_W-1:0] CLOCK_MHZ_RST = 16'd100;
    localparam logic [CLOCK_W-1:0] MS_DIVISOR    = 16'd1000;

    // ceil(2^38 / 1000), exact for every 32-bit dividend
    localparam int                    MS_RECIP_W = 29;
    localparam logic [MS_RECIP_W-1:0] MS_RECIP   = 29'h1062_4DD3;
    localparam int                    MS_SHIFT   = 38;

    typedef enum logic [OP_W-1:0] {
        OP_START           = 2'd0,
        OP_READ_US         = 2'd1,
        OP_READ_US_RESTART = 2'd2,
        OP_READ_MS         = 2'd3
    } op_t;

endpackage

### sv/swtb_if.sv
// valid/ready channels of the stopwatch timer bank: request, response, clock config

interface swtb_req_if
    import swtb_pkg::*;
();
    logic                 valid;
    logic                 ready;
    op_t                  op;
    logic [INDEX_W-1:0]   timer_index;
    logic [CYCLE_W-1:0]   now_cycles;

    modport source (output valid, output op, output timer_index, output now_cycles,
                    input ready);
    modport sink   (input valid, input op, input timer_index, input now_cycles,
                    output ready);
endinterface

interface swtb_resp_if
    import swtb_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CYCLE_W-1:0]   elapsed;
    logic                 in_range;

    modport source (output valid, output elapsed, output in_range, input ready);
    modport sink   (input valid, input elapsed, input in_range, output ready);
endinterface

interface swtb_cfg_if
    import swtb_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CLOCK_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/stopwatch_timer_bank.sv
// stopwatch timer bank: stamps in a synchronous ram, shared 32-step restoring divider
// order: idle accepts, load forms the difference, div runs for in-range reads, fin registers the result
// throughput: one request at a time, next request taken the cycle after the result is registered
// the divider retires one quotient bit per cycle; a ms read adds one multiply by 1/1000
// reset clears the stamp valid bits so every timer reads a zero stamp; clock_mhz resets to 100
// the result register lets a new request start while the previous word still waits
module stopwatch_timer_bank
    import swtb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    swtb_req_if.sink       req,
    swtb_resp_if.source    resp,
    swtb_cfg_if.sink       cfg
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(CYCLE_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t                 state_reg;
    logic [CLOCK_W-1:0]     clock_mhz_reg;
    logic [NUM_TIMERS-1:0]  stamp_vld_reg;
    logic [CYCLE_W-1:0]     stamp_mem [NUM_TIMERS];
    logic [CYCLE_W-1:0]     stamp_rd_reg;
    logic                   vld_rd_reg;
    op_t                    op_reg;
    logic                   in_range_reg;
    logic [CYCLE_W-1:0]     now_reg;
    logic                   ms_pending_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CYCLE_W-1:0]     quo_reg;
    logic [CLOCK_W-1:0]     rem_reg;
    logic [CLOCK_W-1:0]     dvs_reg;
    logic [CYCLE_W-1:0]     result_reg;
    logic                   out_valid_reg;
    logic [CYCLE_W-1:0]     out_elapsed_reg;
    logic                   out_in_range_reg;

    logic                   req_fire;
    logic                   req_in_range;
    logic [IDX_W-1:0]       mem_addr;
    logic                   mem_we;
    logic [CYCLE_W-1:0]     diff;
    logic [CLOCK_W:0]       trial;
    logic                   trial_ge;
    logic [CLOCK_W:0]       trial_sub;
    logic                   out_free;
    logic                   out_load;
    logic [CYCLE_W+MS_RECIP_W-1:0] ms_prod;
    logic [CYCLE_W-1:0]     ms_quo;

    assign req.ready    = (state_reg == ST_IDLE);
    assign req_fire     = req.valid && req.ready;
    assign req_in_range = ({1'b0, req.timer_index} < (INDEX_W + 1)'(NUM_TIMERS));
    assign mem_addr     = req_in_range ? req.timer_index[IDX_W-1:0] : '0;
    assign mem_we       = req_fire && req_in_range &&
                          (req.op == OP_START || req.op == OP_READ_US_RESTART);

    assign cfg.ready    = 1'b1;

    assign resp.valid    = out_valid_reg;
    assign resp.elapsed  = out_elapsed_reg;
    assign resp.in_range = out_in_range_reg;
    assign out_free      = !out_valid_reg || resp.ready;
    assign out_load      = (state_reg == ST_FIN) && !ms_pending_reg && out_free;

    // a timer never started reads as a zero stamp
    assign diff = now_reg - (vld_rd_reg ? stamp_rd_reg : '0);

    // restoring step: a zero divisor always subtracts and gives all ones
    assign trial     = {rem_reg, quo_reg[CYCLE_W-1]};
    assign trial_ge  = (trial >= {1'b0, dvs_reg});
    assign trial_sub = trial - {1'b0, dvs_reg};

    // microseconds to milliseconds by reciprocal multiply
    assign ms_prod = result_reg * MS_RECIP;
    assign ms_quo  = CYCLE_W'(ms_prod >> MS_SHIFT);

    // stamp ram, read before write on the same entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stamp_mem[mem_addr] <= req.now_cycles;
        end
        if (req_fire)
        begin
            stamp_rd_reg <= stamp_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            clock_mhz_reg    <= CLOCK_MHZ_RST;
            stamp_vld_reg    <= '0;
            vld_rd_reg       <= 1'b0;
            op_reg           <= OP_START;
            in_range_reg     <= 1'b0;
            now_reg          <= '0;
            ms_pending_reg   <= 1'b0;
            cnt_reg          <= '0;
            quo_reg          <= '0;
            rem_reg          <= '0;
            dvs_reg          <= '0;
            result_reg       <= '0;
            out_valid_reg    <= 1'b0;
            out_elapsed_reg  <= '0;
            out_in_range_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                clock_mhz_reg <= cfg.data;
            end

            if (mem_we)
            begin
                stamp_vld_reg[mem_addr] <= 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (resp.valid && resp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        op_reg       <= req.op;
                        in_range_reg <= req_in_range;
                        now_reg      <= req.now_cycles;
                        vld_rd_reg   <= stamp_vld_reg[mem_addr];
                        state_reg    <= ST_LOAD;
                    end
                end

                ST_LOAD:
                begin
                    rem_reg        <= '0;
                    quo_reg        <= diff;
                    dvs_reg        <= clock_mhz_reg;
                    cnt_reg        <= '0;
                    ms_pending_reg <= in_range_reg && (op_reg == OP_READ_MS);
                    result_reg     <= '0;
                    if (!in_range_reg)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        case (op_reg)
                            OP_START:
                            begin
                                state_reg <= ST_FIN;
                            end
                            default:
                            begin
                                state_reg <= ST_DIV;
                            end
                        endcase
                    end
                end

                ST_DIV:
                begin
                    quo_reg <= {quo_reg[CYCLE_W-2:0], trial_ge};
                    rem_reg <= trial_ge ? trial_sub[CLOCK_W-1:0] : trial[CLOCK_W-1:0];
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(CYCLE_W - 1))
                    begin
                        result_reg <= {quo_reg[CYCLE_W-2:0], trial_ge};
                        state_reg  <= ST_FIN;
                    end
                end

                ST_FIN:
                begin
                    if (ms_pending_reg)
                    begin
                        // the reciprocal multiply turns microseconds into milliseconds first
                        ms_pending_reg <= 1'b0;
                        result_reg     <= ms_quo;
                    end
                    else if (out_free)
                    begin
                        out_elapsed_reg  <= result_reg;
                        out_in_range_reg <= in_range_reg;
                        state_reg        <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### sv/swtb_checker.sv
// port-level checks of the stopwatch timer bank and their bind
module swtb_checker
    import swtb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  logic                resp_valid,
    input  logic                resp_ready,
    input  logic [CYCLE_W-1:0]  resp_elapsed,
    input  logic                resp_in_range
);

    // a waiting result word is not withdrawn
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_ready |=> resp_valid)
        else $error("result word dropped while stalled");

    // a waiting result word keeps its payload
    a_resp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_ready |=> $stable(resp_elapsed) && $stable(resp_in_range))
        else $error("result payload changed while stalled");

    // bad index always reports zero elapsed time
    a_bad_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_in_range |-> resp_elapsed == '0)
        else $error("out of range timer gave nonzero elapsed");

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

endmodule

bind stopwatch_timer_bank swtb_checker u_swtb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .resp_valid    (resp.valid),
    .resp_ready    (resp.ready),
    .resp_elapsed  (resp.elapsed),
    .resp_in_range (resp.in_range)
);
